### rtl/akx_pkg.sv
`default_nettype none

package akx_pkg;

  // Round keys are numbered 0 (the cipher key) to LastRound.
  localparam int unsigned RoundW = 4;
  localparam logic [RoundW-1:0] FirstRound = 4'd0;
  localparam logic [RoundW-1:0] LastRound = 4'd10;

  localparam int unsigned KeyW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned WordW = 32;

  // AES forward S-box, indexed by the input byte.
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constant used to derive round key (cur + 1) from round key cur.
  function automatic logic [7:0] akx_rcon(input logic [RoundW-1:0] cur);
    logic [7:0] rc;
    rc = 8'h00;
    unique case (cur)
      4'd0:    rc = 8'h01;
      4'd1:    rc = 8'h02;
      4'd2:    rc = 8'h04;
      4'd3:    rc = 8'h08;
      4'd4:    rc = 8'h10;
      4'd5:    rc = 8'h20;
      4'd6:    rc = 8'h40;
      4'd7:    rc = 8'h80;
      4'd8:    rc = 8'h1b;
      4'd9:    rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

`default_nettype wire

### rtl/akx_round_unit.sv
`default_nettype none

// One step of the AES-128 key schedule: derives the next round key from the
// current one. Shared by all ten rounds under the sequencer in the top level.
module akx_round_unit
  import akx_pkg::*;
(
  input  wire logic [KeyW-1:0] cur_key,
  input  wire logic [7:0]      rcon,
  output logic      [KeyW-1:0] next_key
);

  logic [WordW-1:0] w0, w1, w2, w3;
  logic [WordW-1:0] rot_w, sub_w, mix_w;
  logic [WordW-1:0] n0, n1, n2, n3;

  // Word 0 sits in the top bits, as byte 0 does.
  assign w0 = cur_key[127:96];
  assign w1 = cur_key[95:64];
  assign w2 = cur_key[63:32];
  assign w3 = cur_key[31:0];

  // RotWord, SubWord and the round constant on the last word.
  assign rot_w = {w3[23:0], w3[31:24]};
  assign sub_w = {SBOX[rot_w[31:24]], SBOX[rot_w[23:16]],
                  SBOX[rot_w[15:8]], SBOX[rot_w[7:0]]};
  assign mix_w = sub_w ^ {rcon, 24'h000000};

  // Each new word chains off the one before it.
  assign n0 = w0 ^ mix_w;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  assign next_key = {n0, n1, n2, n3};

endmodule

`default_nettype wire

### rtl/aes128_key_expansion.sv
`default_nettype none

// Channel   Handshake                 Payload
// input     start & !busy             in_key_hi, in_key_lo
// result    out_valid                 out_round_key_hi/lo, out_round_number,
//                                     out_last_key
//
// An item is taken at an edge with start high and busy low. Round keys 0 to
// 10 then appear in order from the key register, one per cycle, and the
// single round unit is reused once per round. busy drops during the cycle
// that shows round key 10, so a new item can follow without a gap. Reset
// clears the sequencer; the receiver cannot stall.
module aes128_key_expansion
  import akx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [HalfW-1:0]  in_key_hi,
  input  wire logic [HalfW-1:0]  in_key_lo,
  output logic                   out_valid,
  output logic [HalfW-1:0]       out_round_key_hi,
  output logic [HalfW-1:0]       out_round_key_lo,
  output logic [RoundW-1:0]      out_round_number,
  output logic                   out_last_key
);

  logic              active_r, active_nxt;
  logic [RoundW-1:0] round_r, round_nxt;
  logic [KeyW-1:0]   key_r, key_nxt;
  logic [KeyW-1:0]   next_key;
  logic              at_last;
  logic              accept;

  akx_round_unit u_round (
    .cur_key  (key_r),
    .rcon     (akx_rcon(round_r)),
    .next_key (next_key)
  );

  assign at_last = active_r && (round_r == LastRound);
  assign busy    = active_r && !at_last;
  assign accept  = start && !busy;

  // Sequencer: load a new key, otherwise step one round per cycle up to the last round, then go idle.
  always_comb begin
    active_nxt = active_r;
    round_nxt  = round_r;
    key_nxt    = key_r;
    priority if (accept) begin
      active_nxt = 1'b1;
      round_nxt  = FirstRound;
      key_nxt    = {in_key_hi, in_key_lo};
    end else if (at_last) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      round_nxt = round_r + 4'd1;
      key_nxt   = next_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      round_r  <= FirstRound;
    end else begin
      active_r <= active_nxt;
      round_r  <= round_nxt;
    end
    key_r <= key_nxt;
  end

  // The held round key is the result of this cycle.
  assign out_valid        = active_r;
  assign out_round_key_hi = key_r[127:64];
  assign out_round_key_lo = key_r[63:0];
  assign out_round_number = round_r;
  assign out_last_key     = at_last;

`ifndef SYNTHESIS
  // An accepted key shows round key 0 on the next cycle.
  a_first_round: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid && out_round_number == FirstRound))
    else $error("round key 0 did not follow an accepted item");

  // Round keys come back to back with increasing numbers.
  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_round_number != LastRound) |=>
      (out_valid && out_round_number == $past(out_round_number) + 4'd1))
    else $error("round key sequence broken");

  // Without a new item, the run ends after the last round key.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_last_key && !start) |=> !out_valid)
    else $error("result strobe after the last round key");

  // The block is busy exactly while a run has rounds left to show.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (out_valid && !out_last_key))
    else $error("busy outside a run");
`endif

endmodule

`default_nettype wire

### test/aes128_key_expansion_tb.sv
`default_nettype none

module aes128_key_expansion_tb
  import akx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomKeys = 160;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles = 20;

  typedef struct {
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
  } cipher_key_t;

  typedef struct {
    logic [HalfW-1:0]  hi;
    logic [HalfW-1:0]  lo;
    logic [RoundW-1:0] rnd;
    logic              last;
  } round_key_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [HalfW-1:0]  in_key_hi;
  logic [HalfW-1:0]  in_key_lo;
  logic              out_valid;
  logic [HalfW-1:0]  out_round_key_hi;
  logic [HalfW-1:0]  out_round_key_lo;
  logic [RoundW-1:0] out_round_number;
  logic              out_last_key;

  cipher_key_t keys_to_send[$];
  round_key_t  round_keys_due[$];
  logic [7:0]  sbox_lut[256];
  logic [7:0]  rcon_lut[10];

  logic        key_taken;
  int unsigned keys_total;
  int unsigned keys_sent;
  int unsigned keys_accepted;
  int unsigned round_keys_checked;
  int unsigned errors;
  int unsigned quiet_cycles;

  aes128_key_expansion dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_key_hi(in_key_hi),
    .in_key_lo(in_key_lo),
    .out_valid(out_valid),
    .out_round_key_hi(out_round_key_hi),
    .out_round_key_lo(out_round_key_lo),
    .out_round_number(out_round_number),
    .out_last_key(out_last_key)
  );

  always #10 clk = ~clk;

  // Multiply by x in GF(2^8) with the AES polynomial.
  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    logic [7:0] y;
    p = 8'h00;
    x = a;
    y = b;
    for (int k = 0; k < 8; k++) begin
      if (y[0]) p ^= x;
      x = gf_double(x);
      y = y >> 1;
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // S-box entry from its definition: the field inverse (x^254), then the affine map.
  function automatic logic [7:0] sbox_entry(input logic [7:0] b);
    logic [7:0] inv;
    logic [7:0] sq;
    inv = 8'h01;
    sq = b;
    for (int k = 1; k < 8; k++) begin
      sq = gf_mul(sq, sq);
      inv = gf_mul(inv, sq);
    end
    return inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
  endfunction

  // Runs the full key schedule and queues the eleven round keys in order.
  function automatic void queue_round_keys(input logic [HalfW-1:0] hi,
                                           input logic [HalfW-1:0] lo);
    logic [31:0] w[44];
    logic [31:0] t;
    round_key_t  rk;
    w[0] = hi[63:32];
    w[1] = hi[31:0];
    w[2] = lo[63:32];
    w[3] = lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rcon_lut[i/4 - 1], 24'h0};
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r <= 10; r++) begin
      rk.hi = {w[4*r], w[4*r+1]};
      rk.lo = {w[4*r+2], w[4*r+3]};
      rk.rnd = RoundW'(r);
      rk.last = (RoundW'(r) == LastRound);
      round_keys_due.push_back(rk);
    end
  endfunction

  function automatic void add_key(input logic [HalfW-1:0] hi, input logic [HalfW-1:0] lo);
    cipher_key_t k;
    k.hi = hi;
    k.lo = lo;
    keys_to_send.push_back(k);
  endfunction

  function automatic logic [HalfW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Driver: offers the next key once the current one is taken, idling at the
  // rate of the current phase (31 percent, then 57 percent, then none).
  always @(negedge clk) begin
    int unsigned idle_pct;
    idle_pct = (keys_sent < keys_total / 3) ? 31 :
               (keys_sent < 2 * keys_total / 3) ? 57 : 0;
    if (rst_n && (!start || key_taken)) begin
      if (keys_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_key_hi <= keys_to_send[0].hi;
        in_key_lo <= keys_to_send[0].lo;
        void'(keys_to_send.pop_front());
        keys_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each round key against the oldest one due, then records
  // an accepted key and queues its schedule.
  always @(posedge clk) begin
    round_key_t want;
    if (rst_n && out_valid) begin
      if (round_keys_due.size() == 0) begin
        $display("%0t: unexpected round key %h_%h round %0d last %b", $time,
                 out_round_key_hi, out_round_key_lo, out_round_number, out_last_key);
        errors++;
      end else begin
        want = round_keys_due.pop_front();
        round_keys_checked++;
        if (out_round_key_hi !== want.hi) begin
          $display("%0t: round_key_hi expected %h actual %h", $time, want.hi,
                   out_round_key_hi);
          errors++;
        end
        if (out_round_key_lo !== want.lo) begin
          $display("%0t: round_key_lo expected %h actual %h", $time, want.lo,
                   out_round_key_lo);
          errors++;
        end
        if (out_round_number !== want.rnd) begin
          $display("%0t: round_number expected %0d actual %0d", $time, want.rnd,
                   out_round_number);
          errors++;
        end
        if (out_last_key !== want.last) begin
          $display("%0t: last_key expected %b actual %b", $time, want.last, out_last_key);
          errors++;
        end
      end
    end
    key_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      queue_round_keys(in_key_hi, in_key_lo);
      keys_accepted++;
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout after %0d quiet cycles, %0d round keys still due", quiet_cycles,
               round_keys_due.size());
      $display("aes128_key_expansion_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] rc;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_key_hi = '0;
    in_key_lo = '0;
    key_taken = 1'b0;
    keys_sent = 0;
    keys_accepted = 0;
    round_keys_checked = 0;
    errors = 0;
    quiet_cycles = 0;

    // Build the S-box and round constants from their definitions.
    for (int b = 0; b < 256; b++) sbox_lut[b] = sbox_entry(8'(b));
    rc = 8'h01;
    for (int i = 0; i < 10; i++) begin
      rcon_lut[i] = rc;
      rc = gf_double(rc);
    end

    // Directed keys: extremes, the standard example key, patterns and lone bits.
    add_key(64'h0, 64'h0);
    add_key('1, '1);
    add_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    add_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    add_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    add_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    add_key(64'h8000000000000000, 64'h0);
    add_key(64'h0, 64'h0000000000000001);
    add_key(64'h0000000000000001, 64'h8000000000000000);
    add_key(64'h0, '1);
    add_key('1, 64'h0);
    add_key(64'h0000000100000000, 64'h0000000000000100);
    add_key(64'hffffffff00000000, 64'h00000000ffffffff);
    add_key(64'h6363636363636363, 64'h6363636363636363);

    // Random keys: mostly dense random, some sparse and some nearly all ones.
    for (int n = 0; n < RandomKeys; n++) begin
      case ($urandom_range(9))
        0: add_key(rand64() & rand64() & rand64(), rand64() & rand64() & rand64());
        1: add_key(rand64() | rand64() | rand64(), rand64() | rand64() | rand64());
        default: add_key(rand64(), rand64());
      endcase
    end
    keys_total = keys_to_send.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (keys_accepted < keys_total) @(posedge clk);
    while (round_keys_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Expanded %0d cipher keys (directed patterns and random), checked %0d round keys",
             keys_accepted, round_keys_checked);
    $display("under sender idling of 31 percent, 57 percent and none.");
    if (errors == 0 && round_keys_due.size() == 0) begin
      $display("aes128_key_expansion_tb OK");
    end else begin
      $display("aes128_key_expansion_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
